// ===== src/tof_window_sum_diff_search_defines.svh =====
// Assertion macros for the checker file of the TOF window search.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef TOF_WINDOW_SUM_DIFF_SEARCH_DEFINES_SVH
`define TOF_WINDOW_SUM_DIFF_SEARCH_DEFINES_SVH

// clocked property, off while reset is asserted
`define TWSDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen at a clock edge
`define TWSDS_NEVER(lbl, cond, msg) \
	`TWSDS_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/twsds_pkg.sv =====
// Shared types and constants of the TOF window sum/difference search.
// No dependencies.
package twsds_pkg;

	localparam int TOF_W   = 21;          // hit time of flight, signed
	localparam int LEAF_W  = TOF_W + 1;   // +/- tof without overflow
	localparam int WLEN_W  = 4;
	localparam int CTR_W   = 24;          // sum_center, diff_center
	localparam int HW_W    = 23;          // sum_width, diff_width
	localparam int CFG_W   = 24;
	localparam int CIDX_W  = 3;
	localparam int FIRST_W = 6;
	localparam int IN_TD_W = 24;
	localparam int OUT_TD_W = 8;

	typedef enum logic [CIDX_W-1:0] {
		REG_WIN_LEN     = 3'd0,
		REG_SUM_CENTER  = 3'd1,
		REG_SUM_WIDTH   = 3'd2,
		REG_DIFF_CENTER = 3'd3,
		REG_DIFF_WIDTH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NONE  = 2'd1,
		ST_FEW   = 2'd2
	} status_t;

	// per-item control that travels beside the sum pipeline
	typedef struct packed {
		logic                vld;
		logic                last;
		logic                eval;   // window complete, test it
		logic                few;    // event shorter than window at its last hit
		logic [FIRST_W-1:0]  start;
	} tag_t;

endpackage

// ===== src/twsds_cell.sv =====
// One delay-line cell: holds one hit TOF and shifts it to its neighbor.
// Gives its signed share of the window sum and difference. Uses twsds_pkg.
module twsds_cell import twsds_pkg::*; #(
	parameter int AGE = 0,
	parameter int N_W = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift_en,
	input  logic signed [TOF_W-1:0]  tof_in,
	input  logic        [N_W-1:0]    win_n,
	output logic signed [TOF_W-1:0]  tof_out,
	output logic signed [LEAF_W-1:0] s_part,
	output logic signed [LEAF_W-1:0] d_part
);

	logic signed [TOF_W-1:0]  tof_q;
	logic        [N_W-1:0]    half_n;
	logic                     in_win;
	logic                     in_b;
	logic signed [LEAF_W-1:0] tof_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tof_q <= '0;
		end else if (shift_en) begin
			tof_q <= tof_in;
		end
	end

	assign tof_out = tof_q;
	assign half_n  = win_n >> 1;
	assign in_win  = N_W'(AGE) < win_n;
	// newest floor(N/2) hits form sum B, the older ones sum A
	assign in_b    = N_W'(AGE) < half_n;
	assign tof_ext = LEAF_W'(tof_q);

	always_comb begin
		s_part = in_win ? tof_ext : '0;
		if (!in_win) begin
			d_part = '0;
		end else if (in_b) begin
			d_part = tof_ext;
		end else begin
			d_part = -tof_ext;
		end
	end

endmodule

// ===== src/twsds_tree.sv =====
// Registered binary adder tree for the window sum and difference, with a
// register at every level. Uses twsds_pkg.
module twsds_tree import twsds_pkg::*; #(
	parameter int N_LEAF = 8,
	parameter int SUM_W  = 25
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [LEAF_W-1:0] s_leaf [N_LEAF],
	input  logic signed [LEAF_W-1:0] d_leaf [N_LEAF],
	output logic signed [SUM_W-1:0]  s_sum,
	output logic signed [SUM_W-1:0]  d_sum
);

	localparam int LVL = $clog2(N_LEAF);
	localparam int P   = 2 ** LVL;

	logic signed [SUM_W-1:0] s_lf [P];
	logic signed [SUM_W-1:0] d_lf [P];
	logic signed [SUM_W-1:0] s_node_q [1:P-1];
	logic signed [SUM_W-1:0] d_node_q [1:P-1];

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N_LEAF) begin : g_used
			assign s_lf[i] = SUM_W'(s_leaf[i]);
			assign d_lf[i] = SUM_W'(d_leaf[i]);
		end else begin : g_pad
			assign s_lf[i] = '0;
			assign d_lf[i] = '0;
		end
	end

	// heap order: node i adds nodes 2i and 2i+1, leaves sit at P..2P-1
	for (genvar i = 1; i < P; i++) begin : g_node
		if (2 * i >= P) begin : g_bottom
			always_ff @(posedge clk) begin
				if (en) begin
					s_node_q[i] <= s_lf[2*i-P] + s_lf[2*i+1-P];
					d_node_q[i] <= d_lf[2*i-P] + d_lf[2*i+1-P];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (en) begin
					s_node_q[i] <= s_node_q[2*i] + s_node_q[2*i+1];
					d_node_q[i] <= d_node_q[2*i] + d_node_q[2*i+1];
				end
			end
		end
	end

	assign s_sum = s_node_q[1];
	assign d_sum = d_node_q[1];

endmodule

// ===== src/tof_window_sum_diff_search.sv =====
// Channel   Dir  Fields (low bit up)                 Item
// s_axis    in   tdata: hit_tof[20:0], 0[23:21]      one ion hit, tlast = last_hit
//                tlast: last_hit
// m_axis    out  tdata: first_hit[5:0], 0[7:6]       one result per event
//                tuser: search_status[1:0]
// cfg       in   cfg_wr_en, cfg_index, cfg_wr_data   register write, no wait
//
// One hit per cycle while s_axis_tready is high. A result passes through the
// delay-line cell, the adder tree levels, the center subtract, then the window
// test into the output register before it shows on m_axis.
// arst_n clears the delay line, counters, match state and pipeline valids.
// s_axis_tready drops only while the output register holds an untaken result
// and another result waits at the end of the pipeline; then all stages hold.
// Depends on twsds_pkg, twsds_cell, twsds_tree.
module tof_window_sum_diff_search import twsds_pkg::*; #(
	parameter int MAX_WINDOW = 8,
	parameter int MAX_HITS   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_TD_W-1:0]  s_axis_tdata,   // hit_tof[20:0]
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_TD_W-1:0] m_axis_tdata,   // first_hit[5:0]
	output logic [1:0]          m_axis_tuser,   // search_status[1:0]
	input  logic                cfg_wr_en,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_wr_data
);

	localparam int N_W   = $clog2(MAX_WINDOW + 1);
	localparam int LVL   = $clog2(MAX_WINDOW);
	localparam int SUM_W = LEAF_W + LVL;
	localparam int CMP_W = ((SUM_W > CTR_W) ? SUM_W : CTR_W) + 2;
	localparam int CNT_W = $clog2(MAX_HITS + 1);
	localparam int TAG_N = LVL + 2;

	// configuration
	logic        [WLEN_W-1:0] win_len_q;
	logic signed [CTR_W-1:0]  sum_center_q;
	logic        [HW_W-1:0]   sum_width_q;
	logic signed [CTR_W-1:0]  diff_center_q;
	logic        [HW_W-1:0]   diff_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q     <= WLEN_W'(2);
			sum_center_q  <= '0;
			sum_width_q   <= '0;
			diff_center_q <= '0;
			diff_width_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WIN_LEN:     win_len_q     <= cfg_wr_data[WLEN_W-1:0];
				REG_SUM_CENTER:  sum_center_q  <= cfg_wr_data[CTR_W-1:0];
				REG_SUM_WIDTH:   sum_width_q   <= cfg_wr_data[HW_W-1:0];
				REG_DIFF_CENTER: diff_center_q <= cfg_wr_data[CTR_W-1:0];
				REG_DIFF_WIDTH:  diff_width_q  <= cfg_wr_data[HW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window length, clamped to 1..MAX_WINDOW
	logic [N_W-1:0] eff_n;

	always_comb begin
		if (win_len_q == '0) begin
			eff_n = N_W'(1);
		end else if (int'(win_len_q) > MAX_WINDOW) begin
			eff_n = N_W'(MAX_WINDOW);
		end else begin
			eff_n = N_W'(win_len_q);
		end
	end

	// input side: hit counter and item tag
	logic             stall;
	logic             accept;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_new;
	logic             in_range;
	tag_t             tag_in;
	tag_t             tag_q [TAG_N];
	logic [N_W-1:0]   win_n_s0;

	assign s_axis_tready = !stall;
	assign accept        = s_axis_tvalid && !stall;
	assign in_range      = cnt_q < CNT_W'(MAX_HITS);
	assign cnt_new       = in_range ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		tag_in.vld   = accept;
		tag_in.last  = s_axis_tlast;
		tag_in.eval  = in_range && (int'(cnt_new) >= int'(eff_n));
		tag_in.few   = int'(cnt_new) < int'(eff_n);
		tag_in.start = FIRST_W'(int'(cnt_new) - int'(eff_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= s_axis_tlast ? '0 : cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAG_N; i++) begin
				tag_q[i] <= '0;
			end
		end else if (!stall) begin
			tag_q[0] <= tag_in;
			for (int i = 1; i < TAG_N; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			win_n_s0 <= eff_n;
		end
	end

	// delay line of cells, age 0 is the newest hit
	logic signed [TOF_W-1:0]  tof_chain [MAX_WINDOW];
	logic signed [LEAF_W-1:0] s_part    [MAX_WINDOW];
	logic signed [LEAF_W-1:0] d_part    [MAX_WINDOW];

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		logic signed [TOF_W-1:0] cell_in;

		if (k == 0) begin : g_head
			assign cell_in = s_axis_tdata[TOF_W-1:0];
		end else begin : g_link
			assign cell_in = tof_chain[k-1];
		end

		twsds_cell #(
			.AGE (k),
			.N_W (N_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept && in_range),
			.tof_in   (cell_in),
			.win_n    (win_n_s0),
			.tof_out  (tof_chain[k]),
			.s_part   (s_part[k]),
			.d_part   (d_part[k])
		);
	end

	logic signed [SUM_W-1:0] win_sum;
	logic signed [SUM_W-1:0] win_diff;

	twsds_tree #(
		.N_LEAF (MAX_WINDOW),
		.SUM_W  (SUM_W)
	) u_tree (
		.clk    (clk),
		.en     (!stall),
		.s_leaf (s_part),
		.d_leaf (d_part),
		.s_sum  (win_sum),
		.d_sum  (win_diff)
	);

	// distance from the centers
	logic signed [CMP_W-1:0] sum_err_q;
	logic signed [CMP_W-1:0] diff_err_q;

	always_ff @(posedge clk) begin
		if (!stall) begin
			sum_err_q  <= CMP_W'(win_sum) - CMP_W'(sum_center_q);
			diff_err_q <= CMP_W'(win_diff) - CMP_W'(diff_center_q);
		end
	end

	// window test and per-event match tracking
	logic signed [CMP_W-1:0] sw_ext;
	logic signed [CMP_W-1:0] dw_ext;
	logic                    hit_match;
	logic                    found_q;
	logic [FIRST_W-1:0]      start_q;
	logic                    found_now;
	logic [FIRST_W-1:0]      start_now;
	tag_t                    tag_end;
	logic                    res_here;

	assign sw_ext    = CMP_W'(sum_width_q);
	assign dw_ext    = CMP_W'(diff_width_q);
	assign tag_end   = tag_q[TAG_N-1];
	// |e| < w written as -w < e < w
	assign hit_match = tag_end.vld && tag_end.eval &&
		(sum_err_q < sw_ext) && (sum_err_q > -sw_ext) &&
		(diff_err_q < dw_ext) && (diff_err_q > -dw_ext);
	assign found_now = found_q || hit_match;
	assign start_now = found_q ? start_q : tag_end.start;
	assign res_here  = tag_end.vld && tag_end.last;
	assign stall     = res_here && m_axis_tvalid && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			start_q <= '0;
		end else if (!stall && tag_end.vld) begin
			if (tag_end.last) begin
				found_q <= 1'b0;
			end else if (hit_match && !found_q) begin
				found_q <= 1'b1;
				start_q <= tag_end.start;
			end
		end
	end

	// output register
	logic               out_vld_q;
	status_t            status_q;
	logic [FIRST_W-1:0] first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_here && !stall) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_here && !stall) begin
			if (tag_end.few) begin
				status_q <= ST_FEW;
				first_q  <= '0;
			end else if (found_now) begin
				status_q <= ST_FOUND;
				first_q  <= start_now;
			end else begin
				status_q <= ST_NONE;
				first_q  <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TD_W'(first_q);
	assign m_axis_tuser  = status_q;

endmodule

// ===== src/twsds_checker.sv =====
// Port-level checks of the TOF window search, bound to its top level.
// Uses twsds_pkg and tof_window_sum_diff_search_defines.svh.
`include "tof_window_sum_diff_search_defines.svh"

module twsds_checker import twsds_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OUT_TD_W-1:0] m_axis_tdata,
	input logic [1:0]          m_axis_tuser
);

	// a result waiting for the sink keeps its value
	`TWSDS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// input is only held back by an untaken result
	`TWSDS_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

	// start index is only reported with a match
	`TWSDS_ASSERT(a_first_zero, m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == '0, "first_hit set without a match")

	`TWSDS_NEVER(a_status_code, m_axis_tvalid && m_axis_tuser == 2'd3, "undefined search status")

endmodule

bind tof_window_sum_diff_search twsds_checker u_twsds_checker (.*);

// ===== tb/tb.sv =====
// Testbench for tof_window_sum_diff_search: hit items in, one search result per event out.
// Results are checked against a window search predictor in this file or a typed row.
// Depends on twsds_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
	import twsds_pkg::*;

	localparam int MAX_WIN      = 8;
	localparam int MAX_EV_HITS  = 64;
	localparam int ITEM_TARGET  = 1350;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [TOF_W-1:0] TOF_MAX = 21'h0FFFFF;
	localparam logic [TOF_W-1:0] TOF_MIN = 21'h100000;
	localparam logic [CFG_W-1:0] CTR_MAX = 24'h7FFFFF;
	localparam logic [CFG_W-1:0] CTR_MIN = 24'h800000;
	localparam logic [CFG_W-1:0] HW_MAX  = 24'h7FFFFF;

	typedef struct packed {
		status_t             status;
		logic [FIRST_W-1:0]  first;
	} search_result_t;

	typedef struct {
		bit                  is_cfg;
		cfg_reg_t            reg_idx;
		logic [CFG_W-1:0]    value;
		logic [TOF_W-1:0]    tof;
		bit                  last;
		bit                  typed;   // result written in the row, not from the predictor
		search_result_t      want;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_TD_W-1:0]  s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_TD_W-1:0] m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                cfg_wr_en;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_wr_data;

	// window search predictor state and its copy of the registers
	logic signed [TOF_W-1:0] tof_line [MAX_WIN];
	int                      ev_hits;
	bit                      ev_found;
	logic [FIRST_W-1:0]      ev_start;
	logic [WLEN_W-1:0]       win_len_r;
	logic signed [CTR_W-1:0] sum_center_r;
	logic signed [CTR_W-1:0] diff_center_r;
	logic [HW_W-1:0]         sum_width_r;
	logic [HW_W-1:0]         diff_width_r;

	search_result_t search_results_q[$];
	dir_row_t       dir_rows[$];

	int fail_count;
	int cycle_count;
	int items_sent;
	int phases;
	int n_found, n_none, n_few;
	int src_burst, snk_burst;

	tof_window_sum_diff_search #(
		.MAX_WINDOW(MAX_WIN),
		.MAX_HITS  (MAX_EV_HITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int eff_len(logic [WLEN_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_WIN)
			return MAX_WIN;
		return int'(v);
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// mostly random waits, with runs of back-to-back items now and then
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic dir_row_t row(bit is_cfg, cfg_reg_t reg_idx, logic [CFG_W-1:0] value,
			logic [TOF_W-1:0] tof, bit last, bit typed, status_t status,
			logic [FIRST_W-1:0] first);
		dir_row_t r;
		r.is_cfg      = is_cfg;
		r.reg_idx     = reg_idx;
		r.value       = value;
		r.tof         = tof;
		r.last        = last;
		r.typed       = typed;
		r.want.status = status;
		r.want.first  = first;
		return r;
	endfunction

	task automatic window_search_step(input logic signed [TOF_W-1:0] tof, input bit last,
			output bit has_res, output search_result_t res, output bit counted);
		int     n;
		longint a, b, t, sc, dc, sw, dw;
		n       = eff_len(win_len_r);
		has_res = 0;
		counted = 0;
		res     = '{status: ST_NONE, first: '0};
		if (ev_hits < MAX_EV_HITS) begin
			counted = 1;
			for (int k = MAX_WIN - 1; k > 0; k--)
				tof_line[k] = tof_line[k-1];
			tof_line[0] = tof;
			ev_hits++;
			if (!ev_found && ev_hits >= n) begin
				a  = 0;
				b  = 0;
				sc = sum_center_r;
				dc = diff_center_r;
				sw = sum_width_r;
				dw = diff_width_r;
				// newest floor(n/2) hits form sum B, the older ones sum A
				for (int age = 0; age < n; age++) begin
					t = tof_line[age];
					if (age >= n / 2)
						a += t;
					else
						b += t;
				end
				if (mag(a + b - sc) < sw && mag(b - a - dc) < dw) begin
					ev_found = 1;
					ev_start = FIRST_W'(ev_hits - n);
				end
			end
		end
		if (last) begin
			has_res = 1;
			if (ev_hits < n)
				res = '{status: ST_FEW, first: '0};
			else if (ev_found)
				res = '{status: ST_FOUND, first: ev_start};
			else
				res = '{status: ST_NONE, first: '0};
			ev_hits  = 0;
			ev_found = 0;
		end
	endtask

	task automatic send_hit(input logic [TOF_W-1:0] tof, input bit last, input bit typed,
			input search_result_t want);
		int             gap;
		bit             has_res;
		bit             counted;
		search_result_t res;
		gap = draw_wait(src_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TD_W-TOF_W){1'b0}}, tof};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		window_search_step(tof, last, has_res, res, counted);
		if (counted)
			items_sent++;
		if (has_res) begin
			if (typed)
				res = want;
			search_results_q = {search_results_q, res};
			case (res.status)
				ST_FOUND: n_found++;
				ST_NONE:  n_none++;
				default:  n_few++;
			endcase
		end
	endtask

	// every event ends with its last hit, so an empty queue plus a drain means idle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (search_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_WIN_LEN:     win_len_r     = val[WLEN_W-1:0];
			REG_SUM_CENTER:  sum_center_r  = val[CTR_W-1:0];
			REG_SUM_WIDTH:   sum_width_r   = val[HW_W-1:0];
			REG_DIFF_CENTER: diff_center_r = val[CTR_W-1:0];
			REG_DIFF_WIDTH:  diff_width_r  = val[HW_W-1:0];
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		search_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (search_results_q.size() == 0) begin
				$error("result with no event pending: search_status %0d first_hit %0d",
					m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				exp_res = search_results_q.pop_front();
				if (m_axis_tuser !== exp_res.status) begin
					$error("search_status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata !== {{(OUT_TD_W-FIRST_W){1'b0}}, exp_res.first}) begin
					$error("first_hit: expected %0d, got %0d", exp_res.first, m_axis_tdata);
					fail_count++;
				end
			end
		end
	end

	// result sink with random stalls
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_wait(snk_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		logic [WLEN_W-1:0] wl;
		logic [TOF_W-1:0]  tof;
		int                n, na, nb, base, spread, mode, events, len;
		logic [CFG_W-1:0]  sc, sw, dc, dw;

		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_WIN_LEN;
		cfg_wr_data   = '0;
		fail_count    = 0;
		cycle_count   = 0;
		items_sent    = 0;
		phases        = 0;
		n_found       = 0;
		n_none        = 0;
		n_few         = 0;
		src_burst     = 0;
		snk_burst     = 0;
		ev_hits       = 0;
		ev_found      = 0;
		ev_start      = '0;
		win_len_r     = 4'd2;
		sum_center_r  = '0;
		diff_center_r = '0;
		sum_width_r   = '0;
		diff_width_r  = '0;
		foreach (tof_line[i])
			tof_line[i] = '0;

		// reset values: window of 2, zero widths match nothing
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd0, 1, 1, ST_FEW, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, TOF_MAX, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, TOF_MIN, 1, 1, ST_NONE, '0)};
		// widest gates: the first window always matches
		dir_rows = {dir_rows, row(1, REG_SUM_WIDTH, HW_MAX, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_DIFF_WIDTH, HW_MAX, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, TOF_MAX, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, TOF_MAX, 1, 1, ST_FOUND, '0)};
		// length 0 acts as 1
		dir_rows = {dir_rows, row(1, REG_WIN_LEN, 24'd0, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, -21'sd5, 1, 1, ST_FOUND, '0)};
		// length above the maximum acts as 8
		dir_rows = {dir_rows, row(1, REG_WIN_LEN, 24'd15, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd1, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd2, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd3, 1, 1, ST_FEW, '0)};
		// eight minimum hits hit the most negative sum center exactly
		dir_rows = {dir_rows, row(1, REG_SUM_CENTER, CTR_MIN, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_SUM_WIDTH, 24'd1, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_DIFF_WIDTH, 24'd1, '0, 0, 0, ST_NONE, '0)};
		for (int i = 0; i < 8; i++)
			dir_rows = {dir_rows,
				row(0, REG_WIN_LEN, '0, TOF_MIN, i == 7, i == 7, ST_FOUND, '0)};
		// odd window, largest diff center: only a late window matches
		dir_rows = {dir_rows, row(1, REG_WIN_LEN, 24'd3, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_SUM_CENTER, 24'd0, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_SUM_WIDTH, HW_MAX, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_DIFF_CENTER, CTR_MAX, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(1, REG_DIFF_WIDTH, HW_MAX, '0, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd100, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd100, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd50, 0, 0, ST_NONE, '0)};
		dir_rows = {dir_rows, row(0, REG_WIN_LEN, '0, 21'd5000, 1, 0, ST_NONE, '0)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_idle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				send_hit(dir_rows[i].tof, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			phases++;
			wl     = WLEN_W'($urandom_range(0, 15));
			n      = eff_len(wl);
			nb     = n / 2;
			na     = n - nb;
			base   = $urandom_range(0, 200000) - 100000;
			spread = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4000);
			mode   = $urandom_range(0, 9);
			if (mode == 0) begin
				case ($urandom_range(0, 2))
					0: sc = CTR_MIN;
					1: sc = CTR_MAX;
					default: sc = '0;
				endcase
				case ($urandom_range(0, 2))
					0: dc = CTR_MIN;
					1: dc = CTR_MAX;
					default: dc = '0;
				endcase
				sw = $urandom_range(0, 1) ? HW_MAX : '0;
				dw = $urandom_range(0, 1) ? HW_MAX : '0;
			end else if (mode == 1) begin
				sc = CFG_W'($urandom);
				dc = CFG_W'($urandom);
				sw = CFG_W'($urandom);
				dw = CFG_W'($urandom);
			end else begin
				// gates centered on the typical window so that some events match
				sc = CFG_W'(n * base + $urandom_range(0, spread) - spread / 2);
				dc = CFG_W'((nb - na) * base + $urandom_range(0, spread) - spread / 2);
				sw = CFG_W'($urandom_range(0, n * spread / 2 + 2));
				dw = CFG_W'($urandom_range(0, n * spread / 2 + 2));
			end
			write_reg(REG_WIN_LEN, CFG_W'(wl));
			write_reg(REG_SUM_CENTER, sc);
			write_reg(REG_SUM_WIDTH, sw & HW_MAX);
			write_reg(REG_DIFF_CENTER, dc);
			write_reg(REG_DIFF_WIDTH, dw & HW_MAX);

			events = $urandom_range(2, 10);
			repeat (events) begin
				// now and then an event near or past the hit limit
				len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						tof = TOF_W'($urandom);
					else
						tof = TOF_W'(base + $urandom_range(0, spread) - spread / 2);
					send_hit(tof, i == len - 1, 0, '{status: ST_NONE, first: '0});
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (search_results_q.size() != 0) begin
			$error("%0d search results never arrived", search_results_q.size());
			fail_count++;
		end

		$display("Sent %0d counted hits over %0d register settings after the directed rows.",
			items_sent, phases);
		$display("Events: %0d window found, %0d no match, %0d shorter than the window.",
			n_found, n_none, n_few);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== tof_window_sum_diff_search.f =====
+incdir+src
src/twsds_pkg.sv
src/twsds_cell.sv
src/twsds_tree.sv
src/tof_window_sum_diff_search.sv
src/twsds_checker.sv
tb/tb.sv
